@@ design/convolution_3x3_filter_defines.svh @@
// Assertion macros of the 3x3 convolution filter, used by cnv3_merge.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef CONVOLUTION_3X3_FILTER_DEFINES_SVH
`define CONVOLUTION_3X3_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define CNV3_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define CNV3_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cnv3_pkg.sv @@
// Types and constants of the 3x3 convolution filter.
// Depends on nothing; imported by every module of the block.
package cnv3_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int PIX_BITS       = 8;
    localparam int NUM_CHAN       = 3;
    localparam int PIXW           = PIX_BITS * NUM_CHAN;
    localparam int COEF_W         = 12;
    localparam int COEF_FRAC_BITS = 8;
    localparam int KROW_W         = 3 * COEF_W;
    localparam int BIAS_W         = 9;
    localparam int PROD_W         = PIX_BITS + 1 + COEF_W;
    localparam int SUM_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = KROW_W;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = HEIGHT_W'(256);
    localparam logic [KROW_W-1:0]   RST_KERNEL_ROW   = KROW_W'(36'h01C01C01C);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH       = 3'd0,
        CFG_IMAGE_HEIGHT      = 3'd1,
        CFG_COLOR_MODE        = 3'd2,
        CFG_KERNEL_ROW_TOP    = 3'd3,
        CFG_KERNEL_ROW_MIDDLE = 3'd4,
        CFG_KERNEL_ROW_BOTTOM = 3'd5,
        CFG_BIAS_OFFSET       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_red;
        logic [PIX_BITS-1:0] pixel_green;
        logic [PIX_BITS-1:0] pixel_blue;
        logic                frame_start;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0]   out_col;
        logic [HEIGHT_W-1:0] out_row;
        logic [PIX_BITS-1:0] out_red;
        logic [PIX_BITS-1:0] out_green;
        logic [PIX_BITS-1:0] out_blue;
        logic                frame_last;
    } t_out_word;

    // Position and flags of a result travelling beside the window
    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   col;
        logic [HEIGHT_W-1:0] row;
        logic                last;
    } t_tag;

    typedef logic [2:0][2:0][PIXW-1:0]      t_window;
    typedef logic [8:0][PIX_BITS-1:0]       t_chan_win;
    typedef logic [8:0][COEF_W-1:0]         t_coef_set;
    typedef logic [NUM_CHAN-1:0][PIX_BITS-1:0] t_chan_set;

endpackage

@@ design/cnv3_line_buf.sv @@
// Position counters, line store and 3x3 window of the convolution filter.
// Depends on cnv3_pkg.
module cnv3_line_buf import cnv3_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_accept,
    input  t_in_word            i_word,
    input  logic [WIDTH_W-1:0]  i_image_width,
    input  logic [HEIGHT_W-1:0] i_image_height,
    output t_window             o_window,
    output t_tag                o_tag
);

    logic [ADDR_W-1:0]   r_col, n_col, col_now;
    logic [HEIGHT_W-1:0] r_row, n_row, row_now;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                emit, last, col_wrap, row_wrap;

    logic [2*PIXW-1:0]   line_mem [MAX_WIDTH];
    logic [2*PIXW-1:0]   r_rd, rd_eff, wr_data;
    logic [2*PIXW-1:0]   r_fwd_data;
    logic                r_fwd_hit;

    logic                r_s1_valid;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [PIXW-1:0]     r_s1_pix;
    logic                r_s1_emit, r_s1_last;
    logic [ADDR_W-1:0]   r_s1_col;
    logic [HEIGHT_W-1:0] r_s1_row;

    t_window             r_win;
    t_tag                r_tag;

    // Clamp the frame size to the supported range
    always_comb begin
        w_eff = i_image_width;
        if (i_image_width < WIDTH_W'(3)) begin
            w_eff = WIDTH_W'(3);
        end else if (i_image_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        h_eff = (i_image_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : i_image_height;
    end

    // Position of the arriving word and the next position
    always_comb begin
        col_now  = i_word.frame_start ? '0 : r_col;
        row_now  = i_word.frame_start ? '0 : r_row;
        emit     = (col_now >= ADDR_W'(2)) && (row_now >= HEIGHT_W'(2))
                   && ({1'b0, col_now} < w_eff) && (row_now < h_eff);
        last     = ({1'b0, col_now} == (w_eff - WIDTH_W'(1)))
                   && (row_now == (h_eff - HEIGHT_W'(1)));
        col_wrap = ({1'b0, col_now} + WIDTH_W'(1)) >= w_eff;
        row_wrap = ({1'b0, row_now} + (HEIGHT_W + 1)'(1)) >= {1'b0, h_eff};
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : row_now + HEIGHT_W'(1);
        end else begin
            n_col = col_now + ADDR_W'(1);
            n_row = row_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Take the word just written when the same entry is read back next
    assign rd_eff  = r_fwd_hit ? r_fwd_data : r_rd;
    assign wr_data = {rd_eff[PIXW-1:0], r_s1_pix};

    // Line store: one entry per column, one row up low, two rows up high
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= line_mem[col_now];
            if (r_s1_valid) begin
                line_mem[r_s1_addr] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_hit  <= r_s1_valid && (r_s1_addr == col_now);
            r_fwd_data <= wr_data;
        end
    end

    // Hold the arriving word while its column is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_addr <= col_now;
            r_s1_pix  <= {i_word.pixel_blue, i_word.pixel_green, i_word.pixel_red};
            r_s1_emit <= emit;
            r_s1_last <= last;
            r_s1_col  <= col_now - ADDR_W'(1);
            r_s1_row  <= row_now - HEIGHT_W'(1);
        end
    end

    // Advance the window one column and tag the centre pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_tag <= '0;
        end else if (i_en) begin
            r_tag.valid <= r_s1_valid && r_s1_emit;
            r_tag.col   <= r_s1_col;
            r_tag.row   <= r_s1_row;
            r_tag.last  <= r_s1_last;
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= rd_eff[2*PIXW-1:PIXW];
                r_win[1][2] <= rd_eff[PIXW-1:0];
                r_win[2][2] <= r_s1_pix;
            end
        end
    end

    assign o_window = r_win;
    assign o_tag    = r_tag;

endmodule

@@ design/cnv3_lane.sv @@
// One colour lane: nine products, row sums, bias and clamp to 0..255.
// Depends on cnv3_pkg.
module cnv3_lane import cnv3_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  t_chan_win                i_pix,
    input  t_coef_set                i_coef,
    input  logic signed [BIAS_W-1:0] i_bias,
    output logic [PIX_BITS-1:0]      o_value
);

    logic signed [PROD_W-1:0] r_prod [9];
    logic signed [SUM_W-1:0]  r_row  [3];
    logic signed [SUM_W-1:0]  total;
    logic [PIX_BITS-1:0]      r_val, n_val;

    // Add the rows and the scaled bias, then clamp
    always_comb begin
        total = r_row[0] + r_row[1] + r_row[2]
                + (SUM_W'(i_bias) <<< COEF_FRAC_BITS);
        if (total[SUM_W-1]) begin
            n_val = '0;
        end else if (|total[SUM_W-2:COEF_FRAC_BITS+PIX_BITS]) begin
            n_val = '1;
        end else begin
            n_val = total[COEF_FRAC_BITS +: PIX_BITS];
        end
    end

    // Products, then row sums, then the clamped value
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= $signed({1'b0, i_pix[k]}) * $signed(i_coef[k]);
            end
            for (int r = 0; r < 3; r++) begin
                r_row[r] <= SUM_W'(r_prod[3*r]) + SUM_W'(r_prod[3*r+1])
                            + SUM_W'(r_prod[3*r+2]);
            end
            r_val <= n_val;
        end
    end

    assign o_value = r_val;

endmodule

@@ design/cnv3_merge.sv @@
// Joins the lane results with their position into output words; skid stage.
// Depends on cnv3_pkg and convolution_3x3_filter_defines.svh.
`include "convolution_3x3_filter_defines.svh"

module cnv3_merge import cnv3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tag      i_tag,
    input  t_chan_set i_chan,
    input  logic      i_color_mode,
    input  logic      i_ready,
    output logic      o_valid,
    output t_out_word o_word,
    output logic      o_advance
);

    t_tag      r_tag [3];
    t_out_word n_word, r_out, r_skid;
    logic      r_out_valid, r_skid_valid;
    logic      advance, take, fresh;

    assign advance = !r_skid_valid;
    assign take    = r_out_valid && i_ready;
    assign fresh   = advance && r_tag[2].valid;

    // Delay the tag by the depth of the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_tag[k] <= '0;
            end
        end else if (advance) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    // Build the word; gray mode keeps only the red lane
    always_comb begin
        n_word.out_col    = r_tag[2].col;
        n_word.out_row    = r_tag[2].row;
        n_word.out_red    = i_chan[0];
        n_word.out_green  = i_color_mode ? i_chan[1] : '0;
        n_word.out_blue   = i_color_mode ? i_chan[2] : '0;
        n_word.frame_last = r_tag[2].last;
    end

    // Output register with a one-word skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (fresh) begin
            if (!r_out_valid || take) begin
                r_out       <= n_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_word;
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_word    = r_out;
    assign o_advance = advance;

    `CNV3_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `CNV3_ASSERT_NXT(a_skid_fill, r_out_valid && !i_ready && !r_skid_valid && r_tag[2].valid, r_skid_valid, "stalled word not caught in skid")
    `CNV3_ASSERT_NXT(a_skid_hold, r_skid_valid && !i_ready, r_skid_valid && $stable(r_skid), "skid word lost while stalled")

endmodule

@@ design/convolution_3x3_filter.sv @@
// Top level of the 3x3 convolution filter: configuration registers and lanes.
// Depends on cnv3_pkg, cnv3_line_buf, cnv3_lane and cnv3_merge.
//
// Usage:
//   Input channel (i_valid / o_ready / i_word) takes raster-order pixels, one
//   word per ready cycle; frame_start marks column 0, row 0. Output channel
//   (o_valid / i_ready / o_word) gives one filtered word per interior pixel,
//   positioned at the centre pixel one row and one column behind the newest.
//   Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready and must only be written while the block is idle.
// Timing:
//   One pixel per cycle sustained while o_ready stays high. A result reaches
//   the output register through the line store read, window update,
//   product, row sum and clamp stages in three parallel colour lanes.
// Reset:
//   Counters, window and output valid clear; registers take their defaults
//   (256 x 256 gray, box kernel of 28/256, no bias). The line store is not
//   cleared, no pass is needed.
// Stall:
//   A stalled output word holds; the next word parks in a skid register and
//   o_ready drops only while that skid register is full.
module convolution_3x3_filter import cnv3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_word              i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_word             o_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [WIDTH_W-1:0]       r_image_width;
    logic [HEIGHT_W-1:0]      r_image_height;
    logic                     r_color_mode;
    logic [KROW_W-1:0]        r_kernel [3];
    logic signed [BIAS_W-1:0] r_bias_offset;

    logic      advance, accept;
    t_window   window;
    t_tag      tag;
    t_coef_set coef;
    t_chan_set chan;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = advance;
    assign accept      = i_valid && advance;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_color_mode   <= 1'b0;
            r_kernel[0]    <= RST_KERNEL_ROW;
            r_kernel[1]    <= RST_KERNEL_ROW;
            r_kernel[2]    <= RST_KERNEL_ROW;
            r_bias_offset  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:       r_image_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:      r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_COLOR_MODE:        r_color_mode   <= i_cfg_data[0];
                CFG_KERNEL_ROW_TOP:    r_kernel[0]    <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_ROW_MIDDLE: r_kernel[1]    <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_ROW_BOTTOM: r_kernel[2]    <= i_cfg_data[KROW_W-1:0];
                CFG_BIAS_OFFSET:       r_bias_offset  <= $signed(i_cfg_data[BIAS_W-1:0]);
                default: ;
            endcase
        end
    end

    // Unpack the kernel, left column in the low bits
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[3*r+c] = r_kernel[r][COEF_W*c +: COEF_W];
            end
        end
    end

    cnv3_line_buf u_line_buf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_accept       (accept),
        .i_word         (i_word),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_window       (window),
        .o_tag          (tag)
    );

    // One lane per colour channel
    for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
        t_chan_win pix;

        always_comb begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pix[3*r+c] = window[r][c][PIX_BITS*ch +: PIX_BITS];
                end
            end
        end

        cnv3_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (advance),
            .i_pix   (pix),
            .i_coef  (coef),
            .i_bias  (r_bias_offset),
            .o_value (chan[ch])
        );
    end

    cnv3_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (tag),
        .i_chan       (chan),
        .i_color_mode (r_color_mode),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_word       (o_word),
        .o_advance    (advance)
    );

endmodule

@@ verif/tb_convolution_3x3_filter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 convolution filter: raster frames go in and
// every filtered word is predicted per pixel and compared in order of arrival.
// Depends on cnv3_pkg and the convolution_3x3_filter RTL.
module tb_convolution_3x3_filter;
    import cnv3_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 850;
    localparam int PIX_TOP      = 255;

    localparam logic [COEF_W-1:0] COEF_ZERO    = 12'h000;
    localparam logic [COEF_W-1:0] COEF_ONE     = 12'h100;
    localparam logic [COEF_W-1:0] COEF_NEG_ONE = 12'hF00;
    localparam logic [COEF_W-1:0] COEF_FIVE    = 12'h500;
    localparam logic [COEF_W-1:0] COEF_MAX     = 12'h7FF;
    localparam logic [COEF_W-1:0] COEF_MIN     = 12'h800;

    typedef enum int {K_BOX, K_SHARPEN, K_EDGE, K_RANDOM, K_SMALL, K_MAX, K_MIN} t_kernel_kind;
    typedef enum int {TONE_RANDOM, TONE_EXTREME, TONE_BRIGHT, TONE_DARK,
                      TONE_WHITE, TONE_BLACK} t_tone;

    // Pixel-by-pixel model of the filter and the queue of words it still owes
    class filter_scoreboard;
        logic [WIDTH_W-1:0]       width_reg;
        logic [HEIGHT_W-1:0]      height_reg;
        logic                     rgb_reg;
        logic [KROW_W-1:0]        kernel_reg [3];
        logic signed [BIAS_W-1:0] bias_reg;
        logic [2*PIXW-1:0]        line_mem [MAX_WIDTH];
        logic [PIXW-1:0]          window [9];
        int unsigned              col_pos;
        int unsigned              row_pos;
        t_out_word                due_words [$];
        int                       errors;

        function new();
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            rgb_reg    = 1'b0;
            bias_reg   = '0;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            for (int r = 0; r < 3; r++) kernel_reg[r] = RST_KERNEL_ROW;
            for (int i = 0; i < 9; i++) window[i] = '0;
            for (int i = 0; i < MAX_WIDTH; i++) line_mem[i] = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:       width_reg     = data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:      height_reg    = data[HEIGHT_W-1:0];
                CFG_COLOR_MODE:        rgb_reg       = data[0];
                CFG_KERNEL_ROW_TOP:    kernel_reg[0] = data[KROW_W-1:0];
                CFG_KERNEL_ROW_MIDDLE: kernel_reg[1] = data[KROW_W-1:0];
                CFG_KERNEL_ROW_BOTTOM: kernel_reg[2] = data[KROW_W-1:0];
                CFG_BIAS_OFFSET:       bias_reg      = data[BIAS_W-1:0];
                default: ;
            endcase
        endfunction

        // Weighted sum of one channel, bias added, clamped to a pixel
        function logic [PIX_BITS-1:0] filter_channel(int shift);
            longint acc;
            longint level;
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    acc += longint'(window[r*3+c][shift +: PIX_BITS])
                         * longint'($signed(kernel_reg[r][c*COEF_W +: COEF_W]));
                end
            end
            acc += longint'(bias_reg) * (longint'(1) << COEF_FRAC_BITS);
            if (acc < 0) return '0;
            level = acc >>> COEF_FRAC_BITS;
            return (level > PIX_TOP) ? PIX_BITS'(PIX_TOP) : level[PIX_BITS-1:0];
        endfunction

        function void note_pixel(t_in_word w);
            int unsigned     wd;
            int unsigned     ht;
            int unsigned     slot;
            logic [PIXW-1:0] pix;
            logic [PIXW-1:0] up1;
            logic [PIXW-1:0] up2;
            t_out_word       res;
            wd = width_reg;
            if (wd < 3) wd = 3;
            if (wd > MAX_WIDTH) wd = MAX_WIDTH;
            ht = height_reg;
            if (ht < 3) ht = 3;
            if (w.frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            // Read the two rows above, shift the window, store the new column
            slot = (col_pos < MAX_WIDTH) ? col_pos : 0;
            {up2, up1} = line_mem[slot];
            pix = {w.pixel_blue, w.pixel_green, w.pixel_red};
            for (int r = 0; r < 3; r++) begin
                window[r*3]   = window[r*3+1];
                window[r*3+1] = window[r*3+2];
            end
            window[2] = up2;
            window[5] = up1;
            window[8] = pix;
            line_mem[slot] = {up1, pix};
            // Interior pixels only; positions outside a shrunken frame give nothing
            if (col_pos >= 2 && row_pos >= 2 && col_pos < wd && row_pos < ht) begin
                res.out_col    = ADDR_W'(col_pos - 1);
                res.out_row    = HEIGHT_W'(row_pos - 1);
                res.out_red    = filter_channel(0);
                res.out_green  = rgb_reg ? filter_channel(PIX_BITS) : '0;
                res.out_blue   = rgb_reg ? filter_channel(2 * PIX_BITS) : '0;
                res.frame_last = (col_pos == wd - 1) && (row_pos == ht - 1);
                due_words.push_back(res);
            end
            // Advance, wrapping column then row
            if (col_pos + 1 >= wd) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= ht) ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        endfunction

        function void match_field(string name, logic [HEIGHT_W-1:0] want,
                                  logic [HEIGHT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                $error("output word with none due: col %0d row %0d", got.out_col, got.out_row);
                errors++;
                return;
            end
            want = due_words.pop_front();
            match_field("out_col", want.out_col, got.out_col);
            match_field("out_row", want.out_row, got.out_row);
            match_field("out_red", want.out_red, got.out_red);
            match_field("out_green", want.out_green, got.out_green);
            match_field("out_blue", want.out_blue, got.out_blue);
            match_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_word              i_word;
    logic                  o_valid;
    logic                  i_ready;
    t_out_word             o_word;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    filter_scoreboard sb;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               quiet_cycles;
    int               random_words;
    bit               counting;
    bit               full_width_seen;

    convolution_3x3_filter i_dut (.*);

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: stall at random on the falling edge
    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Check accepted words and end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_word(o_word);
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [KROW_W-1:0] kernel_row(t_kernel_kind kind, int r);
        logic [COEF_W-1:0] c [3];
        for (int i = 0; i < 3; i++) c[i] = COEF_W'($urandom_range(511)) - COEF_W'(256);
        case (kind)
            K_BOX:     return RST_KERNEL_ROW;
            K_SHARPEN: return (r == 1) ? {COEF_NEG_ONE, COEF_FIVE, COEF_NEG_ONE}
                                       : {COEF_ZERO, COEF_NEG_ONE, COEF_ZERO};
            K_EDGE:    return (r == 0) ? {COEF_ZERO, COEF_ZERO, COEF_NEG_ONE}
                                       : (r == 1) ? {COEF_ZERO, COEF_ONE, COEF_ZERO}
                                                  : {3{COEF_ZERO}};
            K_RANDOM:  return KROW_W'({$urandom, $urandom});
            K_SMALL:   return {c[2], c[1], c[0]};
            K_MAX:     return {3{COEF_MAX}};
            default:   return {3{COEF_MIN}};
        endcase
    endfunction

    function automatic logic [PIX_BITS-1:0] sample(t_tone tone);
        case (tone)
            TONE_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            TONE_BRIGHT:  return PIX_BITS'($urandom_range(192, 255));
            TONE_DARK:    return PIX_BITS'($urandom_range(63));
            TONE_WHITE:   return 8'hFF;
            TONE_BLACK:   return 8'h00;
            default:      return PIX_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_width();
        case ($urandom_range(9))
            0:       return $urandom_range(2);
            1:       return full_width_seen ? $urandom_range(20, 48) : $urandom_range(11, 20);
            default: return $urandom_range(3, 10);
        endcase
    endfunction

    function automatic int pick_height();
        case ($urandom_range(19))
            0, 1:    return $urandom_range(2);
            2:       return (1 << HEIGHT_W) - 1;
            3, 4:    return $urandom_range(7, 10);
            default: return $urandom_range(3, 6);
        endcase
    endfunction

    // Write one register; bits above its width carry junk that must be ignored
    task automatic write_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value, int bits);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        keep = (CFG_DATA_W'(1) << bits) - CFG_DATA_W'(1);
        data = (CFG_DATA_W'({$urandom, $urandom}) & ~keep) | (value & keep);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Offer one pixel word, with random gaps ahead of it
    task automatic send_pixel(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_word  = w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pixel(w);
        @(negedge i_clk);
    endtask

    task automatic send_pixels(int count, t_tone tone, bit first_fs, bit noisy);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w.pixel_red   = sample(tone);
            w.pixel_green = sample(tone);
            w.pixel_blue  = sample(tone);
            w.frame_start = (i == 0 && first_fs) || (noisy && $urandom_range(149) == 0);
            send_pixel(w);
            if (counting) random_words++;
        end
        i_valid = 1'b0;
    endtask

    // Hold until every owed word has left, then let the pipeline empty
    task automatic drain();
        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_setup(int wd, int ht);
        t_kernel_kind kind;
        int           bias;
        kind = t_kernel_kind'($urandom_range(K_MIN));
        case ($urandom_range(3))
            0:       bias = -PIX_TOP;
            1:       bias = PIX_TOP;
            2:       bias = 0;
            default: bias = $urandom_range(2 * PIX_TOP) - PIX_TOP;
        endcase
        write_cfg(CFG_IMAGE_WIDTH, wd, WIDTH_W);
        write_cfg(CFG_IMAGE_HEIGHT, ht, HEIGHT_W);
        write_cfg(CFG_COLOR_MODE, $urandom_range(1), 1);
        write_cfg(CFG_KERNEL_ROW_TOP, kernel_row(kind, 0), KROW_W);
        write_cfg(CFG_KERNEL_ROW_MIDDLE, kernel_row(kind, 1), KROW_W);
        write_cfg(CFG_KERNEL_ROW_BOTTOM, kernel_row(kind, 2), KROW_W);
        write_cfg(CFG_BIAS_OFFSET, bias, BIAS_W);
    endtask

    // Whole frames, some chained without frame_start, some cut short
    task automatic run_frames();
        int    wd;
        int    ht;
        int    ew;
        int    eh;
        int    frames;
        bit    restart;
        t_tone tone;
        wd = pick_width();
        ht = pick_height();
        load_setup(wd, ht);
        ew = (wd < 3) ? 3 : (wd > MAX_WIDTH) ? MAX_WIDTH : wd;
        eh = (ht < 3) ? 3 : ht;
        restart = 1'b1;
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            tone = t_tone'($urandom_range(TONE_DARK));
            if (eh > 12) begin
                // tall frame: feed its top rows only, the next setup restarts
                send_pixels($urandom_range(3, 8) * ew, tone, 1'b1, 1'b1);
                break;
            end
            if ($urandom_range(7) == 0) begin
                send_pixels($urandom_range(1, ew * eh - 1), tone, 1'b1, 1'b1);
                restart = 1'b1;
            end else begin
                send_pixels(ew * eh, tone, restart || $urandom_range(1), 1'b1);
                restart = 1'b0;
            end
        end
    endtask

    // Change the frame size part way through a frame, then carry on
    task automatic run_resize();
        int    wd;
        int    ht;
        t_tone tone;
        wd = $urandom_range(3, 10);
        ht = $urandom_range(3, 6);
        tone = t_tone'($urandom_range(TONE_DARK));
        load_setup(wd, ht);
        send_pixels($urandom_range(1, wd * ht - 1), tone, 1'b1, 1'b0);
        drain();
        write_cfg(CFG_IMAGE_WIDTH, full_width_seen ? pick_width() : MAX_WIDTH, WIDTH_W);
        full_width_seen = 1'b1;
        if ($urandom_range(1)) write_cfg(CFG_IMAGE_HEIGHT, $urandom_range(8), HEIGHT_W);
        send_pixels($urandom_range(10, 60), tone, 1'b0, 1'b1);
    endtask

    initial begin
        int seg;
        sb = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_word          = '0;
        i_ready         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_IMAGE_WIDTH;
        i_cfg_data      = '0;
        send_idle_pct   = 14;
        recv_idle_pct   = 74;
        quiet_cycles    = 0;
        random_words    = 0;
        counting        = 1'b0;
        full_width_seen = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: undersized frame, white then black frame by wrap alone,
        // then frame_start landing mid-frame
        write_cfg(CFG_IMAGE_WIDTH, 0, WIDTH_W);
        write_cfg(CFG_IMAGE_HEIGHT, 2, HEIGHT_W);
        write_cfg(CFG_COLOR_MODE, 1, 1);
        write_cfg(CFG_KERNEL_ROW_TOP, RST_KERNEL_ROW, KROW_W);
        write_cfg(CFG_KERNEL_ROW_MIDDLE, RST_KERNEL_ROW, KROW_W);
        write_cfg(CFG_KERNEL_ROW_BOTTOM, RST_KERNEL_ROW, KROW_W);
        write_cfg(CFG_BIAS_OFFSET, 0, BIAS_W);
        send_pixels(9, TONE_WHITE, 1'b1, 1'b0);
        send_pixels(9, TONE_BLACK, 1'b0, 1'b0);
        send_pixels(3, TONE_EXTREME, 1'b1, 1'b0);
        send_pixels(3, TONE_RANDOM, 1'b1, 1'b0);
        drain();

        // Random setups; the idle pattern follows progress through the run
        counting = 1'b1;
        seg = 0;
        while (random_words < RANDOM_WORDS) begin
            if (random_words < RANDOM_WORDS / 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 74;
            end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            if (seg == 2) begin
                // one full-width frame, width over range; fills the whole line store
                counting = 1'b0;
                load_setup((1 << WIDTH_W) - 1, 3);
                send_pixels(3 * MAX_WIDTH, TONE_RANDOM, 1'b1, 1'b0);
                counting = 1'b1;
            end else if (seg > 2 && $urandom_range(3) == 0) begin
                run_resize();
            end else begin
                run_frames();
            end
            seg++;
        end

        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ convolution_3x3_filter.f @@
+incdir+design
design/cnv3_pkg.sv
design/cnv3_line_buf.sv
design/cnv3_lane.sv
design/cnv3_merge.sv
design/convolution_3x3_filter.sv
verif/tb_convolution_3x3_filter.sv
